### rtl/valen_pkg.sv
`default_nettype none

package valen_pkg;

	// Input coordinate width and number of CORDIC micro-rotations.
	localparam int COORD_WIDTH  = 16;
	localparam int ITERATIONS   = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int CORDIC_STEPS = (ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : ITERATIONS;

	// CORDIC datapath: coordinates scaled by 2^16, with headroom for the gain.
	localparam int COORD_FRAC   = 16;
	localparam int CORDIC_WIDTH = COORD_WIDTH + COORD_FRAC + 3;

	// Angle accumulator in units of 2^-23 degree.
	localparam int ACC_WIDTH       = 34;
	localparam int ANGLE_FRAC      = 16;
	localparam int ROUND_WIDTH     = ACC_WIDTH - ANGLE_FRAC;
	localparam int HALF_TURN_UNITS = 1509949440;
	localparam int HALF_TURN_OUT   = 23040;
	localparam int FULL_TURN_OUT   = 46080;

	// Square root datapath.
	localparam int SQ_WIDTH       = 2 * COORD_WIDTH;
	localparam int ROOT_WIDTH     = COORD_WIDTH;
	localparam int MAG_FULL_WIDTH = COORD_WIDTH + 1;

	localparam int ANGLE_WIDTH = 16;
	localparam int MAG_WIDTH   = 16;

	// Stages between the input register and the output register.
	localparam int PIPE_DEPTH = (CORDIC_STEPS > COORD_WIDTH + 1) ? CORDIC_STEPS
		: COORD_WIDTH + 1;
	localparam int LATENCY    = PIPE_DEPTH + 1;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] x_coord;
		logic signed [COORD_WIDTH-1:0] y_coord;
	} req_t;

	typedef struct packed {
		logic signed [ANGLE_WIDTH-1:0] angle_deg;
		logic        [MAG_WIDTH-1:0]   magnitude;
	} result_t;

	typedef struct packed {
		logic valid;
		logic y_zero;
		logic x_neg;
	} flags_t;

	// atan(2^-i) in units of 2^-23 degree, rounded to nearest.
	function automatic logic signed [ACC_WIDTH-1:0] atan_unit(input int idx);
		logic signed [ACC_WIDTH-1:0] v;
		case (idx)
			0:  v = ACC_WIDTH'(377487360);
			1:  v = ACC_WIDTH'(222843801);
			2:  v = ACC_WIDTH'(117744544);
			3:  v = ACC_WIDTH'(59768969);
			4:  v = ACC_WIDTH'(30000467);
			5:  v = ACC_WIDTH'(15014858);
			6:  v = ACC_WIDTH'(7509261);
			7:  v = ACC_WIDTH'(3754860);
			8:  v = ACC_WIDTH'(1877459);
			9:  v = ACC_WIDTH'(938733);
			10: v = ACC_WIDTH'(469367);
			11: v = ACC_WIDTH'(234683);
			12: v = ACC_WIDTH'(117342);
			13: v = ACC_WIDTH'(58671);
			14: v = ACC_WIDTH'(29335);
			15: v = ACC_WIDTH'(14668);
			16: v = ACC_WIDTH'(7334);
			17: v = ACC_WIDTH'(3667);
			18: v = ACC_WIDTH'(1833);
			19: v = ACC_WIDTH'(917);
			20: v = ACC_WIDTH'(458);
			21: v = ACC_WIDTH'(229);
			22: v = ACC_WIDTH'(115);
			23: v = ACC_WIDTH'(57);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

### rtl/valen_front.sv
`default_nettype none

module valen_front (
	input  wire                                             clk,
	input  wire                                             arst_n,
	input  wire                                             accept,
	input  valen_pkg::req_t                                 req,
	output valen_pkg::flags_t                               flags_s1,
	output logic signed [valen_pkg::CORDIC_WIDTH-1:0]       cx_s1,
	output logic signed [valen_pkg::CORDIC_WIDTH-1:0]       cy_s1,
	output logic signed [valen_pkg::ACC_WIDTH-1:0]          acc_s1,
	output logic        [valen_pkg::SQ_WIDTH-1:0]           sqx_s1,
	output logic        [valen_pkg::SQ_WIDTH-1:0]           sqy_s1
);

	localparam int W = valen_pkg::COORD_WIDTH;

	logic [W-1:0]        xu, yu, ax, ay;
	logic signed [W:0]   xe, ye, xr, yr;
	logic                y_zero, x_neg;
	logic signed [valen_pkg::ACC_WIDTH-1:0] acc0;

	always_comb begin
		xu     = req.x_coord;
		yu     = req.y_coord;
		y_zero = (yu == '0);
		x_neg  = xu[W-1];
		xe     = $signed({xu[W-1], xu});
		ye     = $signed({yu[W-1], yu});
		// A vector in the left half-plane is turned by half a turn first.
		xr     = x_neg ? -xe : xe;
		yr     = x_neg ? -ye : ye;
		ax     = xu[W-1] ? (~xu + 1'b1) : xu;
		ay     = yu[W-1] ? (~yu + 1'b1) : yu;
		acc0   = '0;
		if (x_neg && !y_zero) begin
			acc0 = yu[W-1] ? -valen_pkg::ACC_WIDTH'(valen_pkg::HALF_TURN_UNITS)
				: valen_pkg::ACC_WIDTH'(valen_pkg::HALF_TURN_UNITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_s1 <= '0;
		end else begin
			flags_s1.valid  <= accept;
			flags_s1.y_zero <= y_zero;
			flags_s1.x_neg  <= x_neg;
		end
	end

	always_ff @(posedge clk) begin
		cx_s1  <= $signed({{2{xr[W]}}, xr, {valen_pkg::COORD_FRAC{1'b0}}});
		cy_s1  <= $signed({{2{yr[W]}}, yr, {valen_pkg::COORD_FRAC{1'b0}}});
		acc_s1 <= acc0;
		sqx_s1 <= valen_pkg::SQ_WIDTH'(ax) * valen_pkg::SQ_WIDTH'(ax);
		sqy_s1 <= valen_pkg::SQ_WIDTH'(ay) * valen_pkg::SQ_WIDTH'(ay);
	end

endmodule

`default_nettype wire

### rtl/valen_cordic.sv
`default_nettype none

module valen_cordic (
	input  wire                                         clk,
	input  wire                                         arst_n,
	input  valen_pkg::flags_t                           flags_in,
	input  wire signed [valen_pkg::CORDIC_WIDTH-1:0]    cx_in,
	input  wire signed [valen_pkg::CORDIC_WIDTH-1:0]    cy_in,
	input  wire signed [valen_pkg::ACC_WIDTH-1:0]       acc_in,
	output valen_pkg::flags_t                           flags_out,
	output logic signed [valen_pkg::ACC_WIDTH-1:0]      acc_out
);

	localparam int D  = valen_pkg::PIPE_DEPTH;
	localparam int N  = valen_pkg::CORDIC_STEPS;
	localparam int CW = valen_pkg::CORDIC_WIDTH;
	localparam int AW = valen_pkg::ACC_WIDTH;

	valen_pkg::flags_t   flags_s [D];
	logic signed [AW-1:0] acc_s  [D];
	logic signed [CW-1:0] cx_s   [N-2];
	logic signed [CW-1:0] cy_s   [N-1];

	for (genvar k = 0; k < D; k++) begin : g_stage
		valen_pkg::flags_t    fl_prev;
		logic signed [AW-1:0] acc_prev;

		if (k == 0) begin : g_first
			assign fl_prev  = flags_in;
			assign acc_prev = acc_in;
		end else begin : g_next
			assign fl_prev  = flags_s[k-1];
			assign acc_prev = acc_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				flags_s[k] <= '0;
			end else begin
				flags_s[k] <= fl_prev;
			end
		end

		if (k < N) begin : g_rot
			logic signed [CW-1:0] cy_prev;
			logic                 dir;

			if (k == 0) begin : g_cy0
				assign cy_prev = cy_in;
			end else begin : g_cyn
				assign cy_prev = cy_s[k-1];
			end

			// Rotate clockwise while y is still above the axis.
			assign dir = !cy_prev[CW-1] && (cy_prev != '0);

			always_ff @(posedge clk) begin
				acc_s[k] <= dir ? acc_prev + valen_pkg::atan_unit(k)
					: acc_prev - valen_pkg::atan_unit(k);
			end

			if (k < N - 1) begin : g_y
				logic signed [CW-1:0] cx_prev;

				if (k == 0) begin : g_cx0
					assign cx_prev = cx_in;
				end else begin : g_cxn
					assign cx_prev = cx_s[k-1];
				end

				always_ff @(posedge clk) begin
					cy_s[k] <= dir ? cy_prev - (cx_prev >>> k) : cy_prev + (cx_prev >>> k);
				end

				if (k < N - 2) begin : g_x
					always_ff @(posedge clk) begin
						cx_s[k] <= dir ? cx_prev + (cy_prev >>> k)
							: cx_prev - (cy_prev >>> k);
					end
				end
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				acc_s[k] <= acc_prev;
			end
		end
	end

	assign flags_out = flags_s[D-1];
	assign acc_out   = acc_s[D-1];

endmodule

`default_nettype wire

### rtl/valen_sqrt.sv
`default_nettype none

module valen_sqrt (
	input  wire                               clk,
	input  wire [valen_pkg::SQ_WIDTH-1:0]     sqx_in,
	input  wire [valen_pkg::SQ_WIDTH-1:0]     sqy_in,
	output logic [valen_pkg::SQ_WIDTH-1:0]    rem_out,
	output logic [valen_pkg::SQ_WIDTH-1:0]    res_out
);

	localparam int D  = valen_pkg::PIPE_DEPTH;
	localparam int W  = valen_pkg::ROOT_WIDTH;
	localparam int SW = valen_pkg::SQ_WIDTH;

	logic [SW-1:0] rem_s [D];
	logic [SW-1:0] res_s [D];

	for (genvar k = 0; k < D; k++) begin : g_stage
		if (k == 0) begin : g_sum
			always_ff @(posedge clk) begin
				rem_s[0] <= sqx_in + sqy_in;
				res_s[0] <= '0;
			end
		end else if (k <= W) begin : g_step
			// One result bit per stage, most significant first.
			localparam logic [SW-1:0] BIT = SW'(1) << (2 * (W - k));
			logic [SW:0] trial;

			assign trial = {1'b0, res_s[k-1]} + {1'b0, BIT};

			always_ff @(posedge clk) begin
				if ({1'b0, rem_s[k-1]} >= trial) begin
					rem_s[k] <= rem_s[k-1] - trial[SW-1:0];
					res_s[k] <= (res_s[k-1] >> 1) + BIT;
				end else begin
					rem_s[k] <= rem_s[k-1];
					res_s[k] <= res_s[k-1] >> 1;
				end
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				rem_s[k] <= rem_s[k-1];
				res_s[k] <= res_s[k-1];
			end
		end
	end

	assign rem_out = rem_s[D-1];
	assign res_out = res_s[D-1];

endmodule

`default_nettype wire

### rtl/valen_final.sv
`default_nettype none

module valen_final (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  valen_pkg::flags_t                       flags_in,
	input  wire signed [valen_pkg::ACC_WIDTH-1:0]   acc_in,
	input  wire [valen_pkg::SQ_WIDTH-1:0]           rem_in,
	input  wire [valen_pkg::SQ_WIDTH-1:0]           res_in,
	output logic                                    done_q,
	output valen_pkg::result_t                      result_q
);

	localparam int AW = valen_pkg::ACC_WIDTH;
	localparam int RW = valen_pkg::ROUND_WIDTH;
	localparam int MW = valen_pkg::MAG_FULL_WIDTH;
	localparam logic signed [RW-1:0] HALF_R = RW'(valen_pkg::HALF_TURN_OUT);
	localparam logic signed [RW-1:0] FULL_R = RW'(valen_pkg::FULL_TURN_OUT);

	logic signed [AW-1:0] rnd;
	logic signed [RW-1:0] a, aw;
	logic [MW-1:0]        mag_full;
	valen_pkg::result_t   res_d;

	always_comb begin
		// Round to nearest, ties upwards, then fold into (-180, 180].
		rnd = acc_in + AW'(1 << (valen_pkg::ANGLE_FRAC - 1));
		a   = $signed(rnd[AW-1:valen_pkg::ANGLE_FRAC]);
		if (a > HALF_R) begin
			aw = a - FULL_R;
		end else if (a <= -HALF_R) begin
			aw = a + FULL_R;
		end else begin
			aw = a;
		end
		if (flags_in.y_zero) begin
			res_d.angle_deg = flags_in.x_neg
				? valen_pkg::ANGLE_WIDTH'(valen_pkg::HALF_TURN_OUT) : '0;
		end else begin
			res_d.angle_deg = valen_pkg::ANGLE_WIDTH'(aw);
		end
		mag_full = {1'b0, res_in[valen_pkg::ROOT_WIDTH-1:0]} + MW'(rem_in > res_in);
		if (64'(mag_full) > 64'hFFFF) begin
			res_d.magnitude = '1;
		end else begin
			res_d.magnitude = valen_pkg::MAG_WIDTH'(mag_full);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= flags_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_d;
	end

endmodule

`default_nettype wire

### rtl/vector_angle_and_length.sv
// Each accepted request passes the input register, the CORDIC and root stages and the
// output register before its result is strobed on done.
// Throughput: one request every cycle when not busy; a rotation or root bit per stage.
// Reset: arst_n clears the valid bits; busy stays high until the first edge after release.
// The receiver cannot stall, so busy never rises once the block is running.
`default_nettype none

module vector_angle_and_length (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  valen_pkg::req_t     req,
	output logic                done,
	output valen_pkg::result_t  result
);

	// The design is a straight pipeline with no back-pressure. An input stage
	// turns left-half-plane vectors by half a turn and forms the two squares.
	// Two parallel chains of equal depth follow: the CORDIC chain, with one
	// micro-rotation per stage, and the square root chain, which forms the sum
	// of squares and then settles one result bit per stage. Shorter chains are
	// padded with plain delay stages, so both arrive together at the output
	// stage, which rounds and folds the angle and rounds the length.

	logic rdy_q;
	logic accept;

	valen_pkg::flags_t                         flags_s1, flags_end;
	logic signed [valen_pkg::CORDIC_WIDTH-1:0] cx_s1, cy_s1;
	logic signed [valen_pkg::ACC_WIDTH-1:0]    acc_s1, acc_end;
	logic        [valen_pkg::SQ_WIDTH-1:0]     sqx_s1, sqy_s1, rem_end, res_end;

	// Requests are refused only while coming out of reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdy_q <= 1'b0;
		end else begin
			rdy_q <= 1'b1;
		end
	end

	assign busy   = !rdy_q;
	assign accept = start && !busy;

	valen_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.req      (req),
		.flags_s1 (flags_s1),
		.cx_s1    (cx_s1),
		.cy_s1    (cy_s1),
		.acc_s1   (acc_s1),
		.sqx_s1   (sqx_s1),
		.sqy_s1   (sqy_s1)
	);

	valen_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.flags_in  (flags_s1),
		.cx_in     (cx_s1),
		.cy_in     (cy_s1),
		.acc_in    (acc_s1),
		.flags_out (flags_end),
		.acc_out   (acc_end)
	);

	valen_sqrt u_sqrt (
		.clk     (clk),
		.sqx_in  (sqx_s1),
		.sqy_in  (sqy_s1),
		.rem_out (rem_end),
		.res_out (res_end)
	);

	valen_final u_final (
		.clk      (clk),
		.arst_n   (arst_n),
		.flags_in (flags_end),
		.acc_in   (acc_end),
		.rem_in   (rem_end),
		.res_in   (res_end),
		.done_q   (done),
		.result_q (result)
	);

	// Every accepted request comes out after the fixed latency.
	a_done_matches_request: assert property (@(posedge clk) disable iff (!arst_n)
		$past(accept, valen_pkg::LATENCY + 1) |-> done)
		else $error("accepted request produced no result strobe");

	// No result is strobed without a request accepted the latency before.
	a_no_stray_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, valen_pkg::LATENCY + 1))
		else $error("result strobe does not match an accepted request");

	// The zero vector gives a zero angle and a zero length.
	a_zero_vector: assert property (@(posedge clk) disable iff (!arst_n)
		done && $past(accept && (req.x_coord == '0) && (req.y_coord == '0),
			valen_pkg::LATENCY + 1)
		|-> (result.angle_deg == '0) && (result.magnitude == '0))
		else $error("zero vector gave a non-zero result");

	// The angle always lies in the half-open range of one turn.
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($signed(result.angle_deg) > -16'sd23040)
			&& ($signed(result.angle_deg) <= 16'sd23040))
		else $error("angle outside one turn");

endmodule

`default_nettype wire

### bench/vector_angle_and_length_tb.sv
`default_nettype none

module vector_angle_and_length_tb;

	// Generous bound on the whole run, in clock cycles.
	localparam int CYCLE_LIMIT = 200000;
	// Random requests in each of the idling phases.
	localparam int PHASE_REQUESTS = 325;
	// Largest number of micro-rotations that the angle table supports.
	localparam int TABLE_SIZE = 24;
	localparam int ROTATIONS = (valen_pkg::ITERATIONS > TABLE_SIZE) ? TABLE_SIZE
		: valen_pkg::ITERATIONS;
	localparam longint DEG_UNITS = 64'sd8388608;
	localparam longint HALF_TURN = 64'sd23040;
	localparam longint FULL_TURN = 64'sd46080;

	// One row of the directed stimulus. Where known is set, want holds a result that
	// can be read straight off the definition; otherwise the predictor supplies it.
	typedef struct packed {
		valen_pkg::req_t    vec;
		logic               known;
		valen_pkg::result_t want;
	} probe_t;

	localparam int PROBES = 21;

	logic               clk    = 1'b0;
	logic               arst_n = 1'b0;
	logic               start  = 1'b0;
	valen_pkg::req_t    req    = '0;
	logic               busy;
	logic               done;
	valen_pkg::result_t result;

	int                 failures = 0;
	int                 cycles   = 0;
	valen_pkg::result_t awaited_polar [$];

	// atan(2^-i) in units of 2^-23 degree, rounded to nearest.
	longint  atan_step_units [TABLE_SIZE] = '{
		64'sd377487360, 64'sd222843801, 64'sd117744544, 64'sd59768969,
		64'sd30000467, 64'sd15014858, 64'sd7509261, 64'sd3754860,
		64'sd1877459, 64'sd938733, 64'sd469367, 64'sd234683,
		64'sd117342, 64'sd58671, 64'sd29335, 64'sd14668,
		64'sd7334, 64'sd3667, 64'sd1833, 64'sd917,
		64'sd458, 64'sd229, 64'sd115, 64'sd57
	};

	// The directed rows: the axes, the corners of the input range, three diagonals of unit
	// length, alternating bit patterns and the vector just below the negative
	// x axis, whose angle rounds to -180 degrees and must wrap round to +180.
	probe_t  probes [PROBES] = '{
		'{'{16'sh0000, 16'sh0000}, 1'b1, '{16'sd0, 16'd0}},
		'{'{16'sh0001, 16'sh0000}, 1'b1, '{16'sd0, 16'd1}},
		'{'{16'shffff, 16'sh0000}, 1'b1, '{16'sd23040, 16'd1}},
		'{'{16'sh7fff, 16'sh0000}, 1'b1, '{16'sd0, 16'd32767}},
		'{'{16'sh8000, 16'sh0000}, 1'b1, '{16'sd23040, 16'd32768}},
		'{'{16'sh0000, 16'sh7fff}, 1'b0, '0},
		'{'{16'sh0000, 16'sh8000}, 1'b0, '0},
		'{'{16'sh0000, 16'sh0001}, 1'b0, '0},
		'{'{16'sh7fff, 16'sh7fff}, 1'b0, '0},
		'{'{16'sh8000, 16'sh8000}, 1'b0, '0},
		'{'{16'sh8000, 16'sh7fff}, 1'b0, '0},
		'{'{16'sh7fff, 16'sh8000}, 1'b0, '0},
		'{'{16'sh8000, 16'shffff}, 1'b0, '0},
		'{'{16'sh8000, 16'sh0001}, 1'b0, '0},
		'{'{16'shffff, 16'sh0001}, 1'b0, '0},
		'{'{16'shffff, 16'shffff}, 1'b0, '0},
		'{'{16'sh0001, 16'shffff}, 1'b0, '0},
		'{'{16'sh0003, 16'shfffc}, 1'b0, '0},
		'{'{16'sh5555, 16'shaaaa}, 1'b0, '0},
		'{'{16'shaaaa, 16'sh5555}, 1'b0, '0},
		'{'{16'shffff, 16'sh8000}, 1'b0, '0}
	};

	vector_angle_and_length dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.result (result)
	);

	always #4 clk = ~clk;

	// Polar form of one vector. The angle comes from a vectoring CORDIC on
	// coordinates scaled by 2^16, the length from an exact integer square root
	// rounded to nearest. Arithmetic right shifts on longint round towards minus
	// infinity, which is the rounding the datapath uses at every micro-rotation.
	function automatic valen_pkg::result_t predict_polar(input valen_pkg::req_t vec);
		longint             x, y, cx, cy, dx, dy, acc, base, ang;
		longint unsigned    rem, root, probe_bit;
		valen_pkg::result_t polar;
		x = $signed(vec.x_coord);
		y = $signed(vec.y_coord);

		// Bit-by-bit square root; the remainder decides the final rounding.
		rem = longint'(x * x + y * y);
		root = 0;
		probe_bit = 64'h4000_0000_0000_0000;
		while (probe_bit > rem)
			probe_bit = probe_bit >> 2;
		while (probe_bit != 0) begin
			if (rem >= root + probe_bit) begin
				rem = rem - (root + probe_bit);
				root = (root >> 1) + probe_bit;
			end else begin
				root = root >> 1;
			end
			probe_bit = probe_bit >> 2;
		end
		if (rem > root)
			root = root + 1;
		if (root > 64'd65535)
			root = 64'd65535;

		if (y == 0) begin
			// On the x axis the angle is exact: nought, or a half turn for negative x.
			ang = (x < 0) ? HALF_TURN : 0;
		end else begin
			// The left half plane is turned through 180 degrees first, so that the
			// CORDIC only ever sees vectors in the right half plane.
			base = 0;
			if (x < 0) begin
				base = (y > 0) ? 64'sd180 : -64'sd180;
				x = -x;
				y = -y;
			end
			cx = x * 64'sd65536;
			cy = y * 64'sd65536;
			acc = 0;
			for (int i = 0; i < ROTATIONS; i++) begin
				dx = cy >>> i;
				dy = cx >>> i;
				if (cy > 0) begin
					cx = cx + dx;
					cy = cy - dy;
					acc = acc + atan_step_units[i];
				end else begin
					cx = cx - dx;
					cy = cy + dy;
					acc = acc - atan_step_units[i];
				end
			end
			acc = acc + base * DEG_UNITS;
			ang = (acc + 64'sd32768) >>> 16;
			if (ang > HALF_TURN)
				ang = ang - FULL_TURN;
			else if (ang <= -HALF_TURN)
				ang = ang + FULL_TURN;
		end

		polar.angle_deg = ang[15:0];
		polar.magnitude = root[15:0];
		return polar;
	endfunction

	// A random vector. Half are uniform over the whole range, which sets every bit
	// both ways; the rest lean on short vectors, the axes, the range limits and the
	// region near the negative x axis where the angle wraps.
	function automatic valen_pkg::req_t random_vector();
		valen_pkg::req_t vec;
		logic [15:0]     corner [5];
		corner = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff};
		vec = valen_pkg::req_t'($urandom());
		case ($urandom_range(0, 9))
			5, 6: begin
				vec.x_coord = 16'($signed($urandom_range(0, 128)) - 64);
				vec.y_coord = 16'($signed($urandom_range(0, 128)) - 64);
			end
			7: begin
				if ($urandom_range(0, 1))
					vec.y_coord = '0;
				else
					vec.x_coord = '0;
			end
			8: begin
				vec.x_coord = corner[$urandom_range(0, 4)];
				vec.y_coord = corner[$urandom_range(0, 4)];
			end
			9: begin
				vec.x_coord = 16'($signed($urandom_range(0, 32767)) - 32768);
				vec.y_coord = 16'($signed($urandom_range(0, 16)) - 8);
			end
			default: begin
			end
		endcase
		return vec;
	endfunction

	// Presents one request, after a random idle stretch, and records what it should
	// produce at the edge that accepts it. Start is left high on return, so that a
	// following request with no gap keeps it high without a second assignment in the
	// same time step; the caller lowers it when the stream stops.
	task automatic send_request(input valen_pkg::req_t vec, input valen_pkg::result_t want,
		input int idle_pct);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= vec;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		awaited_polar.push_back(want);
	endtask

	// Lets the stream run dry: start goes low and the sender waits until every
	// result already requested has been checked.
	task automatic drain_results();
		start <= 1'b0;
		while (awaited_polar.size() != 0)
			@(posedge clk);
	endtask

	// Every strobed result is matched against the oldest outstanding expectation.
	always @(posedge clk) begin : check_result
		valen_pkg::result_t want;
		if (arst_n && done) begin
			if (awaited_polar.size() == 0) begin
				$error("result with no request outstanding: angle_deg %0d, magnitude %0d",
					result.angle_deg, result.magnitude);
				failures++;
			end else begin
				want = awaited_polar.pop_front();
				if (result.angle_deg !== want.angle_deg) begin
					$error("angle_deg: expected %0d, got %0d", want.angle_deg,
						result.angle_deg);
					failures++;
				end
				if (result.magnitude !== want.magnitude) begin
					$error("magnitude: expected %0d, got %0d", want.magnitude,
						result.magnitude);
					failures++;
				end
			end
		end
	end

	// Watchdog on the length of the whole run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin : stimulus
		int                 idle_phase [4];
		valen_pkg::req_t    vec;
		valen_pkg::result_t want;
		// No idling, a mostly idle sender, a second clean stretch, then light idling.
		idle_phase = '{0, 82, 0, 17};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed rows, back to back.
		for (int p = 0; p < PROBES; p++) begin
			want = probes[p].known ? probes[p].want : predict_polar(probes[p].vec);
			send_request(probes[p].vec, want, 0);
		end
		drain_results();

		// Random phases. Between phases the sender holds off until the pipeline
		// has delivered every outstanding result.
		for (int ph = 0; ph < 4; ph++) begin
			for (int n = 0; n < PHASE_REQUESTS; n++) begin
				vec = random_vector();
				send_request(vec, predict_polar(vec), idle_phase[ph]);
			end
			drain_results();
		end

		// Quiet time for any stray strobe to show up.
		repeat (valen_pkg::LATENCY + 4) @(posedge clk);
		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
rtl/valen_pkg.sv
rtl/valen_front.sv
rtl/valen_cordic.sv
rtl/valen_sqrt.sv
rtl/valen_final.sv
rtl/vector_angle_and_length.sv
bench/vector_angle_and_length_tb.sv
